### src/svps_pkg.sv
// ----------------------------------------------------------------------------
// svps_pkg
// Shared widths, register indexes, unit request types and state encodings
// for the stochastic volatility path step block.
// ----------------------------------------------------------------------------
`default_nettype none

package svps_pkg;

    // fixed point widths
    localparam int FX_W      = 48;   // signed Q16.32
    localparam int VAL_W     = 47;   // unsigned Q15.32
    localparam int NOISE_W   = 32;   // signed Q4.28
    localparam int SUM_W     = FX_W + 2;
    localparam int FRAC_Q16  = 32;
    localparam int FRAC_Q4   = 28;

    localparam logic [VAL_W-1:0] MAX_VAL = {VAL_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_MODE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VARIANCE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PRICE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSION_RATE  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSION_LEVEL = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_OF_VARIANCE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEREST_RATE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP       = 4'd7;

    // shift-add multiplier, one digit of the second operand per cycle
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = FX_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int PROD_W      = 2 * FX_W;
    localparam int MUL_ACC_W   = PROD_W + MUL_DIGIT_W;
    localparam int PART_W      = FX_W + MUL_DIGIT_W;

    // digit-by-digit square root, one result bit per cycle
    localparam int ROOT_W     = 40;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    typedef struct packed {
        logic                   go;
        logic signed [FX_W-1:0] a;
        logic signed [FX_W-1:0] b;
        logic                   frac_q4;
    } mul_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [FX_W-1:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic             go;
        logic [VAL_W-1:0] val;
    } root_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] res;
    } root_rsp_t;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_ROOT_V = 14'b00000000000010,
        S_MUL_1  = 14'b00000000000100,
        S_MUL_2  = 14'b00000000001000,
        S_MUL_3  = 14'b00000000010000,
        S_MUL_4  = 14'b00000000100000,
        S_SUM_V  = 14'b00000001000000,
        S_ROOT_N = 14'b00000010000000,
        S_MUL_5  = 14'b00000100000000,
        S_MUL_6  = 14'b00001000000000,
        S_MUL_7  = 14'b00010000000000,
        S_MUL_8  = 14'b00100000000000,
        S_SUM_P  = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } seq_state_t;

    typedef enum logic [2:0] {
        MU_IDLE  = 3'b001,
        MU_RUN   = 3'b010,
        MU_ROUND = 3'b100
    } mul_state_t;

    typedef enum logic [1:0] {
        RT_IDLE = 2'b01,
        RT_RUN  = 2'b10
    } root_state_t;

endpackage

`default_nettype wire

### src/svps_mul.sv
// ----------------------------------------------------------------------------
// svps_mul
// Iterative signed fixed-point multiplier: magnitude shift-add over digits,
// then round half away from zero, saturate to 47 bits and restore the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module svps_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire svps_pkg::mul_req_t req,
    output svps_pkg::mul_rsp_t      rsp
);
    import svps_pkg::*;

    mul_state_t                  state_reg, state_next;
    logic [MUL_ACC_W-1:0]        acc_reg, acc_next;
    logic [FX_W-1:0]             a_reg, a_next;
    logic [FX_W-1:0]             b_reg, b_next;
    logic                        neg_reg, neg_next;
    logic                        frac_reg, frac_next;
    logic [MUL_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic signed [FX_W-1:0]      res_reg, res_next;

    logic [FX_W-1:0]             a_mag;
    logic [FX_W-1:0]             b_mag;
    logic [PART_W-1:0]           part;
    logic [MUL_ACC_W-1:0]        acc_sum;
    logic [PROD_W:0]             rnd;
    logic [PROD_W:0]             shifted;
    logic                        sat;
    logic [VAL_W-1:0]            mag;
    logic [FX_W-1:0]             mag_ext;

    // operand magnitudes
    assign a_mag = req.a[FX_W-1] ? (~req.a + FX_W'(1)) : req.a;
    assign b_mag = req.b[FX_W-1] ? (~req.b + FX_W'(1)) : req.b;

    // one digit of b times a, added at the top and shifted down
    assign part    = {{MUL_DIGIT_W{1'b0}}, a_reg}
                   * {{FX_W{1'b0}}, b_reg[MUL_DIGIT_W-1:0]};
    assign acc_sum = acc_reg + {part, {FX_W{1'b0}}};

    // rounding and saturation of the finished product
    assign rnd     = {1'b0, acc_reg[PROD_W-1:0]}
                   + (frac_reg ? ((PROD_W+1)'(1) << (FRAC_Q4 - 1))
                               : ((PROD_W+1)'(1) << (FRAC_Q16 - 1)));
    assign shifted = frac_reg ? (rnd >> FRAC_Q4) : (rnd >> FRAC_Q16);
    assign sat     = |shifted[PROD_W:VAL_W];
    assign mag     = sat ? MAX_VAL : shifted[VAL_W-1:0];
    assign mag_ext = {1'b0, mag};

    // sequencing of the unit
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            MU_IDLE:
            begin
                if (req.go)
                begin
                    a_next     = a_mag;
                    b_next     = b_mag;
                    neg_next   = req.a[FX_W-1] ^ req.b[FX_W-1];
                    frac_next  = req.frac_q4;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = MU_RUN;
                end
            end
            MU_RUN:
            begin
                acc_next = acc_sum >> MUL_DIGIT_W;
                b_next   = b_reg >> MUL_DIGIT_W;
                cnt_next = cnt_reg + MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = MU_ROUND;
                end
            end
            MU_ROUND:
            begin
                res_next   = neg_reg ? (~mag_ext + FX_W'(1)) : mag_ext;
                done_next  = 1'b1;
                state_next = MU_IDLE;
            end
            default:
            begin
                state_next = MU_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MU_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        neg_reg  <= neg_next;
        frac_reg <= frac_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

### src/svps_root.sv
// ----------------------------------------------------------------------------
// svps_root
// Iterative floor square root of an unsigned Q15.32 value, one result bit per cycle,
// result in unsigned Q8.32.
// ----------------------------------------------------------------------------
`default_nettype none

module svps_root (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire svps_pkg::root_req_t req,
    output svps_pkg::root_rsp_t      rsp
);
    import svps_pkg::*;

    root_state_t              state_reg, state_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [ROOT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                     done_reg, done_next;

    logic [REM_W-1:0]         rem_shift;
    logic [REM_W-1:0]         trial;
    logic                     fits;

    // bring down two radicand bits and try the next root bit
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            RT_IDLE:
            begin
                if (req.go)
                begin
                    rad_next   = {1'b0, req.val, {FRAC_Q16{1'b0}}};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = RT_RUN;
                end
            end
            RT_RUN:
            begin
                rad_next  = rad_reg << 2;
                rem_next  = fits ? (rem_shift - trial) : rem_shift;
                root_next = {root_reg[ROOT_W-2:0], fits};
                cnt_next  = cnt_reg + ROOT_CNT_W'(1);
                if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = RT_IDLE;
                end
            end
            default:
            begin
                state_next = RT_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RT_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = root_reg;

endmodule

`default_nettype wire

### src/stochastic_volatility_path_step_top.sv
// ----------------------------------------------------------------------------
// stochastic_volatility_path_step_top
// One Euler step of a mean-reverting variance and its price, GARCH or Heston
// noise scaling, signed Q16.32, run by a sequencer over a shared multiplier
// and a shared square root unit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   path_start, frac_noise, plain_noise
//  out      output     out_valid / out_stall step_price, step_variance,
//                                            variance_clamped
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  an item takes 8 multiplies, one root of the new variance, plus a root of
//  the old one in Heston mode, and the states for the accept, the two sums
//  and the result hand-off
//  reset clears the path state, the configuration registers and the sequencer
//  a finished result waits in the output register; the next request is
//  taken while it is stalled, and a second result waits for it to drain
// ----------------------------------------------------------------------------
`default_nettype none

module stochastic_volatility_path_step_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                path_start,
    input  wire logic signed [svps_pkg::NOISE_W-1:0] frac_noise,
    input  wire logic signed [svps_pkg::NOISE_W-1:0] plain_noise,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [svps_pkg::FX_W-1:0]         step_price,
    output logic [svps_pkg::VAL_W-1:0]               step_variance,
    output logic                                     variance_clamped,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [svps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [svps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import svps_pkg::*;

    // configuration registers
    logic                    mode_reg;
    logic [VAL_W-1:0]        start_var_reg;
    logic [VAL_W-1:0]        start_price_reg;
    logic [VAL_W-1:0]        rate_reg;
    logic [VAL_W-1:0]        level_reg;
    logic [VAL_W-1:0]        vol_reg;
    logic [FX_W-1:0]         interest_reg;
    logic [VAL_W-1:0]        dt_reg;

    // sequencer and working registers
    seq_state_t              state_reg, state_next;
    logic                    issued_reg, issued_next;
    logic [VAL_W-1:0]        v_reg, v_next;
    logic [FX_W-1:0]         p_reg, p_next;
    logic [NOISE_W-1:0]      fn_reg, fn_next;
    logic [NOISE_W-1:0]      pn_reg, pn_next;
    logic [VAL_W-1:0]        scale_reg, scale_next;
    logic [FX_W-1:0]         prod_reg, prod_next;
    logic [FX_W-1:0]         dv_reg, dv_next;
    logic [FX_W-1:0]         dp_reg, dp_next;
    logic [ROOT_W-1:0]       sq_reg, sq_next;
    logic                    clamp_reg, clamp_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [FX_W-1:0]         out_price_reg, out_price_next;
    logic [VAL_W-1:0]        out_var_reg, out_var_next;
    logic                    out_clamp_reg, out_clamp_next;

    mul_req_t                mul_req;
    mul_rsp_t                mul_rsp;
    root_req_t               root_req;
    root_rsp_t               root_rsp;

    logic                    in_take;
    logic                    mul_state;
    logic                    root_state;
    logic                    unit_done;
    logic                    out_free;
    logic [FX_W-1:0]         level_diff;
    logic [SUM_W-1:0]        sum_v;
    logic [SUM_W-1:0]        sum_p;
    logic                    p_over;
    logic                    p_under;

    svps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    svps_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign mul_state  = state_reg inside {S_MUL_1, S_MUL_2, S_MUL_3, S_MUL_4,
                                          S_MUL_5, S_MUL_6, S_MUL_7, S_MUL_8};
    assign root_state = state_reg inside {S_ROOT_V, S_ROOT_N};
    assign unit_done  = (mul_state && mul_rsp.done) || (root_state && root_rsp.done);

    assign level_diff = {1'b0, level_reg} - {1'b0, v_reg};

    // multiplier operand selection
    always_comb
    begin
        mul_req.go      = mul_state && !issued_reg;
        mul_req.a       = prod_reg;
        mul_req.b       = {1'b0, dt_reg};
        mul_req.frac_q4 = 1'b0;
        case (state_reg)
            S_MUL_1:
            begin
                mul_req.a = {1'b0, rate_reg};
                mul_req.b = level_diff;
            end
            S_MUL_3:
            begin
                mul_req.a = {1'b0, vol_reg};
                mul_req.b = {1'b0, scale_reg};
            end
            S_MUL_4:
            begin
                mul_req.b       = {{(FX_W-NOISE_W){fn_reg[NOISE_W-1]}}, fn_reg};
                mul_req.frac_q4 = 1'b1;
            end
            S_MUL_5:
            begin
                mul_req.a = interest_reg;
                mul_req.b = p_reg;
            end
            S_MUL_7:
            begin
                mul_req.a = {{(FX_W-ROOT_W){1'b0}}, sq_reg};
                mul_req.b = p_reg;
            end
            S_MUL_8:
            begin
                mul_req.b       = {{(FX_W-NOISE_W){pn_reg[NOISE_W-1]}}, pn_reg};
                mul_req.frac_q4 = 1'b1;
            end
            default:
            begin
                mul_req.a = prod_reg;
            end
        endcase
    end

    // square root request
    assign root_req.go  = root_state && !issued_reg;
    assign root_req.val = v_reg;

    // variance and price sums
    assign sum_v = {3'b000, v_reg}
                 + {{2{dv_reg[FX_W-1]}}, dv_reg}
                 + {{2{prod_reg[FX_W-1]}}, prod_reg};
    assign sum_p = {{2{p_reg[FX_W-1]}}, p_reg}
                 + {{2{dp_reg[FX_W-1]}}, dp_reg}
                 + {{2{prod_reg[FX_W-1]}}, prod_reg};
    assign p_over  = !sum_p[SUM_W-1] && (sum_p[SUM_W-2:FX_W-1] != 2'b00);
    assign p_under = sum_p[SUM_W-1] && (sum_p[SUM_W-2:FX_W-1] != 2'b11);

    // step sequencer
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        fn_next        = fn_reg;
        pn_next        = pn_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        dv_next        = dv_reg;
        dp_next        = dp_reg;
        sq_next        = sq_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_price_next = out_price_reg;
        out_var_next   = out_var_reg;
        out_clamp_next = out_clamp_reg;

        if (mul_req.go || root_req.go)
        begin
            issued_next = 1'b1;
        end
        if (unit_done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    fn_next = frac_noise;
                    pn_next = plain_noise;
                    if (path_start)
                    begin
                        v_next     = start_var_reg;
                        p_next     = {1'b0, start_price_reg};
                        scale_next = start_var_reg;
                    end
                    else
                    begin
                        scale_next = v_reg;
                    end
                    state_next = mode_reg ? S_ROOT_V : S_MUL_1;
                end
            end
            S_ROOT_V:
            begin
                if (root_rsp.done)
                begin
                    scale_next = {{(VAL_W-ROOT_W){1'b0}}, root_rsp.res};
                    state_next = S_MUL_1;
                end
            end
            S_MUL_1:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.res;
                    state_next = S_MUL_2;
                end
            end
            S_MUL_2:
            begin
                if (mul_rsp.done)
                begin
                    dv_next    = mul_rsp.res;
                    state_next = S_MUL_3;
                end
            end
            S_MUL_3:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.res;
                    state_next = S_MUL_4;
                end
            end
            S_MUL_4:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.res;
                    state_next = S_SUM_V;
                end
            end
            S_SUM_V:
            begin
                // clamp a negative variance to zero, saturate a large one
                clamp_next = sum_v[SUM_W-1];
                if (sum_v[SUM_W-1])
                begin
                    v_next = '0;
                end
                else if (sum_v[SUM_W-2:VAL_W] != '0)
                begin
                    v_next = MAX_VAL;
                end
                else
                begin
                    v_next = sum_v[VAL_W-1:0];
                end
                state_next = S_ROOT_N;
            end
            S_ROOT_N:
            begin
                if (root_rsp.done)
                begin
                    sq_next    = root_rsp.res;
                    state_next = S_MUL_5;
                end
            end
            S_MUL_5:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.res;
                    state_next = S_MUL_6;
                end
            end
            S_MUL_6:
            begin
                if (mul_rsp.done)
                begin
                    dp_next    = mul_rsp.res;
                    state_next = S_MUL_7;
                end
            end
            S_MUL_7:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.res;
                    state_next = S_MUL_8;
                end
            end
            S_MUL_8:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.res;
                    state_next = S_SUM_P;
                end
            end
            S_SUM_P:
            begin
                // saturate the price to the signed 48-bit range
                if (p_over)
                begin
                    p_next = {1'b0, MAX_VAL};
                end
                else if (p_under)
                begin
                    p_next = {1'b1, {VAL_W{1'b0}}};
                end
                else
                begin
                    p_next = sum_p[FX_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_price_next = p_reg;
                    out_var_next   = v_reg;
                    out_clamp_next = clamp_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, path state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            issued_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            v_reg           <= '0;
            p_reg           <= '0;
            mode_reg        <= 1'b0;
            start_var_reg   <= '0;
            start_price_reg <= '0;
            rate_reg        <= '0;
            level_reg       <= '0;
            vol_reg         <= '0;
            interest_reg    <= '0;
            dt_reg          <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            v_reg         <= v_next;
            p_reg         <= p_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODEL_MODE:      mode_reg        <= cfg_data[0];
                    CFG_START_VARIANCE:  start_var_reg   <= cfg_data[VAL_W-1:0];
                    CFG_START_PRICE:     start_price_reg <= cfg_data[VAL_W-1:0];
                    CFG_REVERSION_RATE:  rate_reg        <= cfg_data[VAL_W-1:0];
                    CFG_REVERSION_LEVEL: level_reg       <= cfg_data[VAL_W-1:0];
                    CFG_VOL_OF_VARIANCE: vol_reg         <= cfg_data[VAL_W-1:0];
                    CFG_INTEREST_RATE:   interest_reg    <= cfg_data[FX_W-1:0];
                    CFG_TIME_STEP:       dt_reg          <= cfg_data[VAL_W-1:0];
                    default:             mode_reg        <= mode_reg;
                endcase
            end
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        fn_reg        <= fn_next;
        pn_reg        <= pn_next;
        scale_reg     <= scale_next;
        prod_reg      <= prod_next;
        dv_reg        <= dv_next;
        dp_reg        <= dp_next;
        sq_reg        <= sq_next;
        clamp_reg     <= clamp_next;
        out_price_reg <= out_price_next;
        out_var_reg   <= out_var_next;
        out_clamp_reg <= out_clamp_next;
    end

    assign out_valid        = out_valid_reg;
    assign step_price       = out_price_reg;
    assign step_variance    = out_var_reg;
    assign variance_clamped = out_clamp_reg;

    // a new result only comes out of the final sequencer step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result presented without a finished step");

    // the two shared units never finish in the same cycle
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_rsp.done && root_rsp.done))
        else $error("multiplier and root finished together");

    // a clamped variance is reported as zero
    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && variance_clamped) |-> (step_variance == '0))
        else $error("clamped variance is not zero");

    // no unit request is outstanding while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !issued_reg)
        else $error("unit request outstanding in idle");

endmodule

`default_nettype wire
